// ===== hdl/pge_pkg.sv =====
// shared types, constants and helpers for the pheromone grid engine
`default_nettype none

package pge_pkg;

  localparam int DefMaxWidth  = 64;
  localparam int DefMaxHeight = 64;

  localparam int LevelW   = 16;
  localparam int MulW     = 16;
  localparam int ProdW    = 2 * MulW;
  localparam int CmdW     = 2;
  localparam int PosW     = 6;
  localparam int SizeW    = 7;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam int NbCount  = 9;
  localparam int NbIdxW   = 4;

  localparam logic [LevelW-1:0] LevelOne  = 16'd32768;
  localparam logic [LevelW-1:0] LevelZero = 16'd0;
  localparam logic [ProdW:0]    RoundHalf = 33'd32768;

  localparam logic [SizeW-1:0]    RstGridWidth  = 7'd64;
  localparam logic [SizeW-1:0]    RstGridHeight = 7'd64;
  localparam logic [CfgDataW-1:0] RstDecayRecip = 16'd59578;

  typedef enum logic [CmdW-1:0] {
    CMD_DEPOSIT = 2'd0,
    CMD_READ    = 2'd1,
    CMD_DECAY   = 2'd2
  } cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1,
    CFG_DECAY_RECIP = 2'd2
  } cfg_idx_t;

  typedef enum logic [10:0] {
    S_CLEAR    = 11'b000_0000_0001,
    S_IDLE     = 11'b000_0000_0010,
    S_BASE     = 11'b000_0000_0100,
    S_DEP_RD   = 11'b000_0000_1000,
    S_DEP_WR   = 11'b000_0001_0000,
    S_READ     = 11'b000_0010_0000,
    S_AREA     = 11'b000_0100_0000,
    S_DEC_INIT = 11'b000_1000_0000,
    S_DEC_RD   = 11'b001_0000_0000,
    S_DEC_MUL  = 11'b010_0000_0000,
    S_DEC_WR   = 11'b100_0000_0000
  } state_t;

  typedef enum logic [1:0] {
    OFF_NONE = 2'd0,
    OFF_NEG  = 2'd1,
    OFF_POS  = 2'd2
  } off_t;

  typedef struct packed {
    off_t dx;
    off_t dy;
  } nb_off_t;

  typedef struct packed {
    logic            en;
    logic [MulW-1:0] a;
    logic [MulW-1:0] b;
  } mul_req_t;

  // neighbor order: center, left, left up, up, right up, right, right down, down, left down
  function automatic nb_off_t nb_off(input logic [NbIdxW-1:0] k);
    nb_off_t o;
    case (k)
      4'd1:    o = '{dx: OFF_NEG,  dy: OFF_NONE};
      4'd2:    o = '{dx: OFF_NEG,  dy: OFF_NEG};
      4'd3:    o = '{dx: OFF_NONE, dy: OFF_NEG};
      4'd4:    o = '{dx: OFF_POS,  dy: OFF_NEG};
      4'd5:    o = '{dx: OFF_POS,  dy: OFF_NONE};
      4'd6:    o = '{dx: OFF_POS,  dy: OFF_POS};
      4'd7:    o = '{dx: OFF_NONE, dy: OFF_POS};
      4'd8:    o = '{dx: OFF_NEG,  dy: OFF_POS};
      default: o = '{dx: OFF_NONE, dy: OFF_NONE};
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pge_ram.sv =====
// generic single-port ram with registered read
`default_nettype none

module pge_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  wire logic                     clk,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic                     we,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== hdl/pge_mul.sv =====
// shared registered multiplier for addressing, grid area and decay
`default_nettype none

module pge_mul
  import pge_pkg::*;
(
  input  wire logic             clk,
  input  wire mul_req_t         req,
  output logic      [ProdW-1:0] prod
);

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= ProdW'(req.a) * ProdW'(req.b);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pheromone_grid_engine_core.sv =====
// top level: config registers, command sequencer, level store and shared multiplier
//
// usage
//   commands enter on start/cmd/pos_x/pos_y/quantity and are taken when start is
//   high and busy is low. each command gives exactly one result, shown on
//   inside_map and the nine level ports for one cycle while done is high; the
//   receiver cannot hold it off.
//   config registers are written on cfg_valid/cfg_ready (ready is always high):
//   index 0 grid width, 1 grid height, 2 decay reciprocal. write them only idle.
//   steps from request to done:
//     deposit: row base, read, write; read neighborhood: row base, nine reads;
//     decay tick: grid area, then read, multiply, write per cell;
//     unused command or position off the map: done in the cycle after it is taken.
//   the single-port level store and the one multiplier shared by address,
//   area and decay math set these steps; one request is worked at a time.
//   after reset the store is swept to zero, one cell per cycle, over all
//   MAX_WIDTH * MAX_HEIGHT cells (4096 by default); busy stays high meanwhile
//   and config writes are still taken.
`default_nettype none

module pheromone_grid_engine_core
  import pge_pkg::*;
#(
  parameter int MAX_WIDTH  = DefMaxWidth,
  parameter int MAX_HEIGHT = DefMaxHeight
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [CmdW-1:0]     cmd,
  input  wire logic [PosW-1:0]     pos_x,
  input  wire logic [PosW-1:0]     pos_y,
  input  wire logic [LevelW-1:0]   quantity,
  output logic                     done,
  output logic                     inside_map,
  output logic      [LevelW-1:0]   level_center,
  output logic      [LevelW-1:0]   level_left,
  output logic      [LevelW-1:0]   level_left_up,
  output logic      [LevelW-1:0]   level_up,
  output logic      [LevelW-1:0]   level_right_up,
  output logic      [LevelW-1:0]   level_right,
  output logic      [LevelW-1:0]   level_right_down,
  output logic      [LevelW-1:0]   level_down,
  output logic      [LevelW-1:0]   level_left_down,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = AW + 1;
  localparam int EW    = $clog2(MAX_WIDTH + 1);
  localparam int EH    = $clog2(MAX_HEIGHT + 1);

  // config registers
  logic [SizeW-1:0]    grid_width;
  logic [SizeW-1:0]    grid_height;
  logic [CfgDataW-1:0] decay_reciprocal;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width       <= RstGridWidth;
      grid_height      <= RstGridHeight;
      decay_reciprocal <= RstDecayRecip;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GRID_WIDTH:  grid_width       <= cfg_data[SizeW-1:0];
        CFG_GRID_HEIGHT: grid_height      <= cfg_data[SizeW-1:0];
        CFG_DECAY_RECIP: decay_reciprocal <= cfg_data;
        default: ;
      endcase
    end
  end

  // sizes in use, clamped to the store
  logic [EW-1:0] eff_w;
  logic [EH-1:0] eff_h;

  assign eff_w = (32'(grid_width) > 32'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(grid_width);
  assign eff_h = (32'(grid_height) > 32'(MAX_HEIGHT)) ? EH'(MAX_HEIGHT) : EH'(grid_height);

  // request registers
  state_t            state;
  cmd_t              cmd_r;
  logic [PosW-1:0]   x_r;
  logic [PosW-1:0]   y_r;
  logic [LevelW-1:0] q_r;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     cell_count;
  logic [NbIdxW-1:0] nb_idx;
  logic [LevelW-1:0] lv [NbCount];

  logic start_inside;
  assign start_inside = (32'(pos_x) < 32'(eff_w)) && (32'(pos_y) < 32'(eff_h));

  // neighbor presence for the latched position
  logic             has_left;
  logic             has_right;
  logic             has_up;
  logic             has_down;
  logic [NbCount-1:0] nb_ok;

  assign has_left  = x_r != '0;
  assign has_up    = y_r != '0;
  assign has_right = (32'(x_r) + 32'd1) < 32'(eff_w);
  assign has_down  = (32'(y_r) + 32'd1) < 32'(eff_h);
  assign nb_ok = {has_left & has_down, has_down, has_right & has_down, has_right,
                  has_right & has_up, has_up, has_left & has_up, has_left, 1'b1};

  // shared multiplier
  mul_req_t         mul_req;
  logic [ProdW-1:0] prod;

  pge_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  // level store
  logic [AW-1:0]     ram_addr;
  logic              ram_we;
  logic [LevelW-1:0] ram_wdata;
  logic [LevelW-1:0] ram_rdata;

  pge_ram #(
    .Width (LevelW),
    .Depth (Depth)
  ) u_ram (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // address math off the row base held in the multiplier
  nb_off_t    off;
  logic [31:0] row_addr;
  logic [31:0] nb_full;
  logic [31:0] cell_full;

  assign off = nb_off(nb_idx);

  always_comb begin
    case (off.dy)
      OFF_NEG: row_addr = prod - 32'(eff_w);
      OFF_POS: row_addr = prod + 32'(eff_w);
      default: row_addr = prod;
    endcase
    case (off.dx)
      OFF_NEG: nb_full = row_addr + 32'(x_r) - 32'd1;
      OFF_POS: nb_full = row_addr + 32'(x_r) + 32'd1;
      default: nb_full = row_addr + 32'(x_r);
    endcase
  end

  assign cell_full = prod + 32'(x_r);

  // deposit and decay arithmetic
  logic [LevelW:0]   dep_sum;
  logic [LevelW-1:0] dep_level;
  logic [ProdW:0]    dec_round;
  logic [LevelW-1:0] dec_raw;
  logic [LevelW-1:0] dec_level;

  assign dep_sum   = {1'b0, ram_rdata} + {1'b0, q_r};
  assign dep_level = (dep_sum > {1'b0, LevelOne}) ? LevelOne : dep_sum[LevelW-1:0];
  assign dec_round = {1'b0, prod} + RoundHalf;
  assign dec_raw   = dec_round[ProdW-1:LevelW];
  assign dec_level = (dec_raw > LevelOne) ? LevelOne : dec_raw;

  always_comb begin
    mul_req   = '{en: 1'b0, a: '0, b: '0};
    ram_addr  = cnt[AW-1:0];
    ram_we    = 1'b0;
    ram_wdata = LevelZero;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_BASE: begin
        mul_req = '{en: 1'b1, a: MulW'(y_r), b: MulW'(eff_w)};
      end
      S_DEP_RD: begin
        ram_addr = cell_full[AW-1:0];
      end
      S_DEP_WR: begin
        ram_addr  = cell_full[AW-1:0];
        ram_we    = 1'b1;
        ram_wdata = dep_level;
      end
      S_READ: begin
        ram_addr = nb_full[AW-1:0];
      end
      S_AREA: begin
        mul_req = '{en: 1'b1, a: MulW'(eff_w), b: MulW'(eff_h)};
      end
      S_DEC_MUL: begin
        mul_req = '{en: 1'b1, a: ram_rdata, b: decay_reciprocal};
      end
      S_DEC_WR: begin
        ram_we    = 1'b1;
        ram_wdata = dec_level;
      end
      default: ;
    endcase
  end

  assign busy = state != S_IDLE;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cnt        <= '0;
      done       <= 1'b0;
      inside_map <= 1'b0;
      nb_idx     <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(Depth - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd_r      <= cmd_t'(cmd);
            x_r        <= pos_x;
            y_r        <= pos_y;
            q_r        <= quantity;
            inside_map <= 1'b0;
            for (int i = 0; i < NbCount; i++) begin
              lv[i] <= LevelZero;
            end
            unique case (cmd_t'(cmd)) inside
              CMD_DEPOSIT, CMD_READ: begin
                if (start_inside) begin
                  state <= S_BASE;
                end else begin
                  done <= 1'b1;
                end
              end
              CMD_DECAY: begin
                state <= S_AREA;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_BASE: begin
          nb_idx <= '0;
          state  <= (cmd_r == CMD_DEPOSIT) ? S_DEP_RD : S_READ;
        end
        S_DEP_RD: begin
          state <= S_DEP_WR;
        end
        S_DEP_WR: begin
          lv[0]      <= dep_level;
          inside_map <= 1'b1;
          done       <= 1'b1;
          state      <= S_IDLE;
        end
        S_READ: begin
          if (nb_idx != '0) begin
            lv[nb_idx - NbIdxW'(1)] <= nb_ok[nb_idx - NbIdxW'(1)] ? ram_rdata : LevelZero;
          end
          nb_idx <= nb_idx + NbIdxW'(1);
          if (nb_idx == NbIdxW'(NbCount)) begin
            inside_map <= 1'b1;
            done       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_AREA: begin
          state <= S_DEC_INIT;
        end
        S_DEC_INIT: begin
          cell_count <= prod[CW-1:0];
          cnt        <= '0;
          if (prod == '0) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_DEC_RD;
          end
        end
        S_DEC_RD: begin
          state <= S_DEC_MUL;
        end
        S_DEC_MUL: begin
          state <= S_DEC_WR;
        end
        S_DEC_WR: begin
          cnt <= cnt + CW'(1);
          if (cnt + CW'(1) == cell_count) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_DEC_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign level_center     = lv[0];
  assign level_left       = lv[1];
  assign level_left_up    = lv[2];
  assign level_up         = lv[3];
  assign level_right_up   = lv[4];
  assign level_right      = lv[5];
  assign level_right_down = lv[6];
  assign level_down       = lv[7];
  assign level_left_down  = lv[8];

endmodule

`default_nettype wire

// ===== hdl/pge_check.sv =====
// port-level checker for the pheromone grid engine, bound to the top level
`default_nettype none

module pge_check
  import pge_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire logic              inside_map,
  input wire logic [LevelW-1:0] level_center,
  input wire logic [LevelW-1:0] level_left,
  input wire logic [LevelW-1:0] level_up
);

  // clearing sweep keeps the block busy right after reset
  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("not busy after reset");

  // a result only shows once the sequencer is back in idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  // an accepted request either starts work or finishes at once
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("request accepted but nothing happened");

  // off-map, unused-command and decay results carry zero levels
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !inside_map) |-> (level_center == '0 && level_left == '0 && level_up == '0))
    else $error("nonzero level on off-map result");

  // levels saturate at one
  a_level_sat: assert property (@(posedge clk) disable iff (rst)
    done |-> (level_center <= LevelOne && level_left <= LevelOne && level_up <= LevelOne))
    else $error("level above one");

endmodule

bind pheromone_grid_engine_core pge_check u_pge_check (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .inside_map   (inside_map),
  .level_center (level_center),
  .level_left   (level_left),
  .level_up     (level_up)
);

`default_nettype wire

// ===== verif/tb_pheromone_grid_engine_core.sv =====
// self-checking testbench for pheromone_grid_engine_core: directed table then random phases
`timescale 1ns / 100ps

module tb_pheromone_grid_engine_core;
  import pge_pkg::*;

  localparam logic [CmdW-1:0]    CmdUnused  = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgUnused  = 2'd3;
  localparam int                 CycleLimit = 600000;
  localparam int                 ItemsPerPhase = 75;
  localparam int                 NumPhases  = 10;

  typedef struct packed {
    logic                         in_map;
    logic [NbCount-1:0][LevelW-1:0] lv;
  } level_view_t;

  typedef struct packed {
    logic                is_reg;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] reg_val;
    logic [CmdW-1:0]     op;
    logic [PosW-1:0]     x;
    logic [PosW-1:0]     y;
    logic [LevelW-1:0]   q;
    logic                typed;
    level_view_t         want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [CmdW-1:0] cmd = '0;
  logic [PosW-1:0] pos_x = '0;
  logic [PosW-1:0] pos_y = '0;
  logic [LevelW-1:0] quantity = '0;
  logic cfg_valid = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic busy, done, inside_map, cfg_ready;
  logic [LevelW-1:0] level_center, level_left, level_left_up, level_up, level_right_up;
  logic [LevelW-1:0] level_right, level_right_down, level_down, level_left_down;

  pheromone_grid_engine_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .pos_x(pos_x),
    .pos_y(pos_y), .quantity(quantity), .done(done), .inside_map(inside_map),
    .level_center(level_center), .level_left(level_left), .level_left_up(level_left_up),
    .level_up(level_up), .level_right_up(level_right_up), .level_right(level_right),
    .level_right_down(level_right_down), .level_down(level_down),
    .level_left_down(level_left_down), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the grid and its registers
  logic [LevelW-1:0] level_mem [DefMaxWidth*DefMaxHeight];
  logic [SizeW-1:0]  grid_w = RstGridWidth;
  logic [SizeW-1:0]  grid_h = RstGridHeight;
  logic [CfgDataW-1:0] decay_mul = RstDecayRecip;
  level_view_t levels_due [$];
  int mismatches = 0;
  int cycles = 0;
  logic row_typed = 1'b0;
  level_view_t row_want = '0;

  // neighbor order: center, left, left up, up, right up, right, right down, down, left down
  int nb_dx [NbCount] = '{0, -1, -1, 0, 1, 1, 1, 0, -1};
  int nb_dy [NbCount] = '{0, 0, -1, -1, -1, 0, 1, 1, 1};
  string lv_name [NbCount] = '{"level_center", "level_left", "level_left_up", "level_up",
                               "level_right_up", "level_right", "level_right_down",
                               "level_down", "level_left_down"};

  function automatic void report(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function automatic level_view_t grid_apply(logic [CmdW-1:0] op, logic [PosW-1:0] x,
                                             logic [PosW-1:0] y, logic [LevelW-1:0] q);
    level_view_t r;
    int w, h, nx, ny;
    longint sum;
    bit on_map;
    r = '0;
    w = (grid_w > DefMaxWidth) ? DefMaxWidth : int'(grid_w);
    h = (grid_h > DefMaxHeight) ? DefMaxHeight : int'(grid_h);
    on_map = (int'(x) < w) && (int'(y) < h);
    case (op)
      CMD_DEPOSIT: if (on_map) begin
        sum = longint'(level_mem[y * w + x]) + longint'(q);
        if (sum > LevelOne) sum = LevelOne;
        level_mem[y * w + x] = sum[LevelW-1:0];
        r.in_map = 1'b1;
        r.lv[0] = sum[LevelW-1:0];
      end
      CMD_READ: if (on_map) begin
        r.in_map = 1'b1;
        for (int k = 0; k < NbCount; k++) begin
          nx = int'(x) + nb_dx[k];
          ny = int'(y) + nb_dy[k];
          if (nx >= 0 && nx < w && ny >= 0 && ny < h) r.lv[k] = level_mem[ny * w + nx];
        end
      end
      CMD_DECAY: begin
        for (int j = 0; j < h; j++) begin
          for (int i = 0; i < w; i++) begin
            sum = (longint'(level_mem[j * w + i]) * longint'(decay_mul) + 32768) >>> 16;
            if (sum > LevelOne) sum = LevelOne;
            level_mem[j * w + i] = sum[LevelW-1:0];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : result_check
    level_view_t got, want, calc;
    if (rst) begin
      foreach (level_mem[a]) level_mem[a] = LevelZero;
      grid_w = RstGridWidth;
      grid_h = RstGridHeight;
      decay_mul = RstDecayRecip;
      levels_due.delete();
    end else begin
      if (done) begin
        got.in_map = inside_map;
        got.lv[0] = level_center;
        got.lv[1] = level_left;
        got.lv[2] = level_left_up;
        got.lv[3] = level_up;
        got.lv[4] = level_right_up;
        got.lv[5] = level_right;
        got.lv[6] = level_right_down;
        got.lv[7] = level_down;
        got.lv[8] = level_left_down;
        if (levels_due.size() == 0) begin
          report($sformatf("unexpected result at cycle %0d", cycles));
        end else begin
          want = levels_due.pop_front();
          if (got.in_map !== want.in_map)
            report($sformatf("inside_map: expected %0d got %0d", want.in_map, got.in_map));
          for (int k = 0; k < NbCount; k++) begin
            if (got.lv[k] !== want.lv[k])
              report($sformatf("%s: expected %0d got %0d", lv_name[k], want.lv[k],
                               got.lv[k]));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GRID_WIDTH:  grid_w = cfg_data[SizeW-1:0];
          CFG_GRID_HEIGHT: grid_h = cfg_data[SizeW-1:0];
          CFG_DECAY_RECIP: decay_mul = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        calc = grid_apply(cmd, pos_x, pos_y, quantity);
        levels_due.push_back(row_typed ? row_want : calc);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("pheromone_grid_engine_core regression: fail");
      $finish;
    end
  end

  task automatic issue(logic [CmdW-1:0] op, logic [PosW-1:0] x, logic [PosW-1:0] y,
                       logic [LevelW-1:0] q);
    start <= 1'b1;
    cmd <= op;
    pos_x <= x;
    pos_y <= y;
    quantity <= q;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (levels_due.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic plan_row_t req_row(logic [CmdW-1:0] op, int x, int y, int q);
    plan_row_t r;
    r = '0;
    r.op = op;
    r.x = x[PosW-1:0];
    r.y = y[PosW-1:0];
    r.q = q[LevelW-1:0];
    return r;
  endfunction

  function automatic plan_row_t typed_row(logic [CmdW-1:0] op, int x, int y, int q,
                                          logic in_map, int center);
    plan_row_t r;
    r = req_row(op, x, y, q);
    r.typed = 1'b1;
    r.want.in_map = in_map;
    r.want.lv[0] = center[LevelW-1:0];
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [CfgIdxW-1:0] idx, int val);
    plan_row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val[CfgDataW-1:0];
    return r;
  endfunction

  int ph_w     [NumPhases] = '{64, 8, 1, 64, 2, 5, 100, 0, 16, 127};
  int ph_h     [NumPhases] = '{64, 8, 1, 2, 64, 7, 3, 9, 16, 127};
  int ph_recip [NumPhases] = '{59578, 59578, 65535, 40000, 32768, 0, 65535, 12345,
                               59578, 59578};
  int ph_idle  [NumPhases] = '{0, 83, 30, 0, 83, 30, 0, 83, 30, 0};

  initial begin : stimulus
    plan_row_t plan [$];
    int weff, heff, area, fx, fy, nx, ny, sel, decays;
    logic [CmdW-1:0] op;
    logic [LevelW-1:0] q;

    // corners, saturation, unused command, off-map, decay and register write cases
    plan.push_back(typed_row(CMD_READ, 0, 0, 0, 1'b1, 0));
    plan.push_back(typed_row(CMD_READ, 63, 63, 65535, 1'b1, 0));
    plan.push_back(typed_row(CMD_DEPOSIT, 0, 0, 32768, 1'b1, 32768));
    plan.push_back(typed_row(CMD_DEPOSIT, 0, 0, 65535, 1'b1, 32768));
    plan.push_back(typed_row(CMD_DEPOSIT, 63, 0, 1, 1'b1, 1));
    plan.push_back(req_row(CMD_DEPOSIT, 0, 63, 12345));
    plan.push_back(req_row(CMD_DEPOSIT, 1, 1, 100));
    plan.push_back(req_row(CMD_READ, 0, 0, 0));
    plan.push_back(req_row(CMD_READ, 1, 1, 0));
    plan.push_back(typed_row(CMD_DEPOSIT, 63, 63, 0, 1'b1, 0));
    plan.push_back(req_row(CMD_DEPOSIT, 62, 62, 500));
    plan.push_back(req_row(CMD_READ, 63, 63, 0));
    plan.push_back(typed_row(CmdUnused, 5, 5, 65535, 1'b0, 0));
    plan.push_back(typed_row(CMD_DECAY, 17, 40, 777, 1'b0, 0));
    plan.push_back(req_row(CMD_READ, 1, 1, 0));
    plan.push_back(reg_row(CFG_GRID_WIDTH, 4));
    plan.push_back(reg_row(CFG_GRID_HEIGHT, 3));
    plan.push_back(typed_row(CMD_READ, 4, 0, 0, 1'b0, 0));
    plan.push_back(typed_row(CMD_READ, 0, 3, 0, 1'b0, 0));
    plan.push_back(typed_row(CMD_DEPOSIT, 63, 63, 500, 1'b0, 0));
    plan.push_back(req_row(CMD_READ, 1, 1, 0));
    plan.push_back(typed_row(CMD_DECAY, 0, 0, 0, 1'b0, 0));
    plan.push_back(reg_row(CFG_DECAY_RECIP, 65535));
    plan.push_back(reg_row(CfgUnused, 65535));
    plan.push_back(typed_row(CMD_DECAY, 63, 63, 65535, 1'b0, 0));
    plan.push_back(req_row(CMD_READ, 3, 2, 0));
    plan.push_back(reg_row(CFG_DECAY_RECIP, 0));
    plan.push_back(typed_row(CMD_DECAY, 0, 0, 0, 1'b0, 0));
    plan.push_back(typed_row(CMD_READ, 1, 1, 0, 1'b1, 0));
    plan.push_back(reg_row(CFG_GRID_WIDTH, 0));
    plan.push_back(typed_row(CMD_READ, 0, 0, 0, 1'b0, 0));
    plan.push_back(typed_row(CMD_DECAY, 0, 0, 0, 1'b0, 0));

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        wait_drained();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        row_typed = plan[i].typed;
        row_want = plan[i].want;
        issue(plan[i].op, plan[i].x, plan[i].y, plan[i].q);
      end
    end
    row_typed = 1'b0;

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      // size registers carry junk in the upper bits, which must be dropped
      write_reg(CFG_GRID_WIDTH, {9'($urandom_range(0, 511)), ph_w[p][SizeW-1:0]});
      write_reg(CFG_GRID_HEIGHT, {9'($urandom_range(0, 511)), ph_h[p][SizeW-1:0]});
      write_reg(CFG_DECAY_RECIP, ph_recip[p][CfgDataW-1:0]);
      weff = (ph_w[p] > DefMaxWidth) ? DefMaxWidth : ph_w[p];
      heff = (ph_h[p] > DefMaxHeight) ? DefMaxHeight : ph_h[p];
      area = weff * heff;
      decays = 0;
      fx = 0;
      fy = 0;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if ($urandom_range(0, 99) < 2) begin
          wait_drained();
        end else if ($urandom_range(0, 99) < ph_idle[p]) begin
          start <= 1'b0;
          do @(negedge clk); while ($urandom_range(0, 99) < ph_idle[p]);
        end
        if (n % 8 == 0 && area > 0) begin
          fx = $urandom_range(0, weff - 1);
          fy = $urandom_range(0, heff - 1);
        end
        sel = $urandom_range(0, 99);
        if (area == 0 || sel >= 90) begin
          nx = $urandom_range(0, 63);
          ny = $urandom_range(0, 63);
        end else if (sel >= 70) begin
          nx = $urandom_range(0, weff - 1);
          ny = $urandom_range(0, heff - 1);
        end else begin
          nx = fx + $urandom_range(0, 2) - 1;
          ny = fy + $urandom_range(0, 2) - 1;
          if (nx < 0) nx = 0;
          if (ny < 0) ny = 0;
          if (nx > 63) nx = 63;
          if (ny > 63) ny = 63;
        end
        sel = $urandom_range(0, 99);
        if (sel < 15) q = LevelW'($urandom_range(0, 65535));
        else if (sel < 30) q = LevelOne;
        else if (sel < 60) q = LevelW'($urandom_range(0, 32768));
        else q = LevelW'($urandom_range(0, 2000));
        sel = $urandom_range(0, 99);
        if ((area <= 64 && sel < 6) || (area <= 1024 && sel < 2) ||
            (sel < 1 && decays < 3)) begin
          op = CMD_DECAY;
          decays++;
        end else if (sel < 9) begin
          op = CmdUnused;
        end else if (sel < 55) begin
          op = CMD_DEPOSIT;
        end else begin
          op = CMD_READ;
        end
        issue(op, nx[PosW-1:0], ny[PosW-1:0], q);
      end
    end

    wait_drained();
    if (mismatches == 0 && levels_due.size() == 0)
      $display("pheromone_grid_engine_core regression: pass");
    else
      $display("pheromone_grid_engine_core regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/pge_pkg.sv
hdl/pge_ram.sv
hdl/pge_mul.sv
hdl/pheromone_grid_engine_core.sv
hdl/pge_check.sv
verif/tb_pheromone_grid_engine_core.sv
